// ----- src/pidf_pkg.sv -----
// Package for the PIDF controller: fixed build settings, register indexes,
// operation codes and shared helper types and functions.
// No dependencies.
package pidf_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned MIN_PERIOD_TICKS = 20;
  localparam int unsigned SETPOINT_RANGE   = 0;

  localparam int unsigned NUM_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(NUM_STEPS);

  localparam logic [46:0] WIDE_LIM = 47'h7FFF_FFFF_FFFF;

  localparam logic [3:0] REG_GAIN_P       = 4'd0;
  localparam logic [3:0] REG_GAIN_I       = 4'd1;
  localparam logic [3:0] REG_GAIN_D       = 4'd2;
  localparam logic [3:0] REG_GAIN_F       = 4'd3;
  localparam logic [3:0] REG_INT_LIMIT    = 4'd4;
  localparam logic [3:0] REG_OUTPUT_LOW   = 4'd5;
  localparam logic [3:0] REG_OUTPUT_HIGH  = 4'd6;
  localparam logic [3:0] REG_FILTER       = 4'd7;

  localparam logic [3:0] OP_IE_MUL = 4'd0;
  localparam logic [3:0] OP_IE_DIV = 4'd1;
  localparam logic [3:0] OP_RATE   = 4'd2;
  localparam logic [3:0] OP_F_MUL  = 4'd3;
  localparam logic [3:0] OP_P_MUL  = 4'd4;
  localparam logic [3:0] OP_D_MUL  = 4'd5;
  localparam logic [3:0] OP_I_MUL  = 4'd6;
  localparam logic [3:0] OP_FL_MUL = 4'd7;
  localparam logic [3:0] OP_FR_MUL = 4'd8;

  typedef struct packed {
    logic start;
    logic is_div;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [46:0] sat47(input logic [63:0] m);
    sat47 = (|m[63:47]) ? WIDE_LIM : m[46:0];
  endfunction

  function automatic logic signed [47:0] with_sign(input logic neg, input logic [46:0] m);
    with_sign = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

// ----- src/pidf_controller_with_limits.sv -----
// PIDF controller with integral clamp, output limits and output filter, Q16.16.
// Top level; depends on pidf_pkg and pidf_shift_engine.
// A word whose elapsed ticks are too few, or the first word after reset, is answered
// straight from the decision state without any arithmetic; a computed update, and more
// so one with the output filter on, is slower, because every product and quotient runs
// through one shared bit-serial multiply/divide unit at 64 steps per operation. One word
// is in work at a time; in_ready is high while the controller is idle, also while a
// result still waits on the output.
module pidf_controller_with_limits (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_measured,
  input  logic signed [31:0] in_target,
  input  logic [31:0]        in_now_tick,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_drive,
  output logic               out_updated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pidf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_BUSY   = 3'd3;
  localparam logic [2:0] ST_LIMIT  = 3'd4;
  localparam logic [2:0] ST_COMMIT = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, gain_f_r;
  logic [30:0]        int_limit_r;
  logic signed [31:0] out_low_r, out_high_r;
  logic [15:0]        filter_r;

  logic signed [31:0] meas_r, tgt_r;
  logic [31:0]        now_r;
  logic signed [47:0] isum_r, isum_new_r;
  logic signed [31:0] prev_err_r, last_drive_r;
  logic [31:0]        last_tick_r;
  logic               first_r;
  logic signed [47:0] rate_r;
  logic [63:0]        tmp_r;
  logic signed [49:0] res_r, fa_r;
  logic               restore_r, neg_r;
  logic signed [31:0] final_r, pend_drive_r;
  logic               pend_upd_r;
  logic [3:0]         op_r;
  logic [2:0]         state_r;
  logic               out_valid_r, out_updated_r;
  logic signed [31:0] out_drive_r;

  eng_cmd_t  eng_cmd;
  eng_stat_t eng_stat;
  logic [31:0] eng_a;
  logic [63:0] eng_b;
  logic        op_neg, op_div;
  logic [32:0] eng_acc;
  logic [63:0] eng_quo;

  logic signed [32:0] tdiff;
  logic signed [31:0] err;
  logic [31:0]        el;
  logic signed [32:0] ediff;
  logic [32:0]        edmag;
  logic signed [33:0] sp, sp_lo, sp_hi, meas34, tgt34;
  logic [33:0]        spmag;
  logic [46:0]        tmag;
  logic signed [47:0] term, qsgn;
  logic signed [48:0] isum_add;
  logic signed [47:0] isum_sat;
  logic signed [49:0] iterm, ilim50;
  logic               iclamp;
  logic signed [49:0] lo50, hi50, lres;
  logic               lhit;
  logic signed [31:0] lres32;
  logic signed [49:0] fb;
  logic signed [50:0] fsum, fadj;
  logic signed [31:0] filt;

  pidf_shift_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (eng_cmd),
    .opa   (eng_a),
    .opb   (eng_b),
    .stat  (eng_stat),
    .acc   (eng_acc),
    .quo   (eng_quo)
  );

  always_comb begin
    tdiff  = $signed({tgt_r[31], tgt_r}) - $signed({meas_r[31], meas_r});
    if (tdiff > 33'sd2147483647) begin
      err = 32'sh7FFF_FFFF;
    end else if (tdiff < -33'sd2147483648) begin
      err = 32'sh8000_0000;
    end else begin
      err = tdiff[31:0];
    end
    el     = now_r - last_tick_r;
    ediff  = $signed({err[31], err}) - $signed({prev_err_r[31], prev_err_r});
    edmag  = ediff[32] ? 33'(-ediff) : 33'(ediff);
    meas34 = 34'(meas_r);
    tgt34  = 34'(tgt_r);
    sp_lo  = meas34 - $signed(34'(SETPOINT_RANGE));
    sp_hi  = meas34 + $signed(34'(SETPOINT_RANGE));
    sp     = tgt34;
    if (SETPOINT_RANGE != 0) begin
      if (tgt34 > sp_hi) begin
        sp = sp_hi;
      end else if (tgt34 < sp_lo) begin
        sp = sp_lo;
      end
    end
    spmag = sp[33] ? 34'(-sp) : 34'(sp);
  end

  always_comb begin
    eng_a  = '0;
    eng_b  = '0;
    op_neg = 1'b0;
    op_div = 1'b0;
    unique case (op_r)
      OP_IE_MUL: begin
        eng_a  = mag32(err);
        eng_b  = {32'd0, el};
        op_neg = err[31];
      end
      OP_IE_DIV: begin
        eng_a  = 32'(TICKS_PER_SECOND);
        eng_b  = tmp_r;
        op_neg = neg_r;
        op_div = 1'b1;
      end
      OP_RATE: begin
        eng_a  = el;
        eng_b  = {31'd0, edmag} * 64'(TICKS_PER_SECOND);
        op_neg = ediff[32];
        op_div = 1'b1;
      end
      OP_F_MUL: begin
        eng_a  = mag32(gain_f_r);
        eng_b  = {30'd0, spmag};
        op_neg = gain_f_r[31] ^ sp[33];
      end
      OP_P_MUL: begin
        eng_a  = mag32(gain_p_r);
        eng_b  = {32'd0, mag32(err)};
        op_neg = gain_p_r[31] ^ err[31];
      end
      OP_D_MUL: begin
        eng_a  = mag32(gain_d_r);
        eng_b  = rate_r[47] ? 64'(-rate_r) : 64'(rate_r);
        op_neg = gain_d_r[31] ^ rate_r[47];
      end
      OP_I_MUL: begin
        eng_a  = mag32(gain_i_r);
        eng_b  = isum_new_r[47] ? 64'(-isum_new_r) : 64'(isum_new_r);
        op_neg = gain_i_r[31] ^ isum_new_r[47];
      end
      OP_FL_MUL: begin
        eng_a  = mag32(last_drive_r);
        eng_b  = {48'd0, filter_r};
        op_neg = last_drive_r[31];
      end
      OP_FR_MUL: begin
        eng_a  = mag32(final_r);
        eng_b  = 64'(17'h10000 - {1'b0, filter_r});
        op_neg = final_r[31];
      end
      default: begin
        eng_a  = '0;
      end
    endcase
    eng_cmd.start  = (state_r == ST_LOAD);
    eng_cmd.is_div = op_div;
  end

  always_comb begin
    tmag     = sat47({1'b0, eng_acc[14:0], eng_quo[63:16]});
    term     = with_sign(neg_r, tmag);
    qsgn     = with_sign(neg_r, sat47(eng_quo));
    isum_add = 49'(isum_r) + 49'(qsgn);
    if (isum_add > $signed({2'b00, WIDE_LIM})) begin
      isum_sat = $signed({1'b0, WIDE_LIM});
    end else if (isum_add < -$signed({2'b00, WIDE_LIM})) begin
      isum_sat = -$signed({1'b0, WIDE_LIM});
    end else begin
      isum_sat = isum_add[47:0];
    end
    ilim50 = $signed({19'd0, int_limit_r});
    iterm  = 50'(term);
    iclamp = (int_limit_r != '0) && !((-ilim50 < iterm) && (iterm < ilim50));
    if (iclamp) begin
      if (iterm > ilim50) begin
        iterm = ilim50;
      end else if (iterm < -ilim50) begin
        iterm = -ilim50;
      end
    end
    lo50 = 50'(out_low_r);
    hi50 = 50'(out_high_r);
    lres = res_r;
    lhit = (out_low_r != out_high_r) && !((lo50 < res_r) && (res_r < hi50));
    if (lhit) begin
      if (res_r > hi50) begin
        lres = hi50;
      end else if (res_r < lo50) begin
        lres = lo50;
      end
    end
    if (lres > 50'sd2147483647) begin
      lres32 = 32'sh7FFF_FFFF;
    end else if (lres < -50'sd2147483648) begin
      lres32 = 32'sh8000_0000;
    end else begin
      lres32 = lres[31:0];
    end
    fb   = neg_r ? -$signed({1'b0, eng_quo[48:0]}) : $signed({1'b0, eng_quo[48:0]});
    fsum = 51'(fa_r) + 51'(fb);
    fadj = fsum[50] ? (fsum + 51'sd65535) : fsum;
    filt = 32'(fadj >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      gain_f_r    <= '0;
      int_limit_r <= '0;
      out_low_r   <= '0;
      out_high_r  <= '0;
      filter_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p_r    <= cfg_data;
        REG_GAIN_I:      gain_i_r    <= cfg_data;
        REG_GAIN_D:      gain_d_r    <= cfg_data;
        REG_GAIN_F:      gain_f_r    <= cfg_data;
        REG_INT_LIMIT:   int_limit_r <= cfg_data[30:0];
        REG_OUTPUT_LOW:  out_low_r   <= cfg_data;
        REG_OUTPUT_HIGH: out_high_r  <= cfg_data;
        REG_FILTER:      filter_r    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_IE_MUL;
      first_r      <= 1'b1;
      isum_r       <= '0;
      prev_err_r   <= '0;
      last_drive_r <= '0;
      last_tick_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r  <= in_measured;
            tgt_r   <= in_target;
            now_r   <= in_now_tick;
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (first_r) begin
            prev_err_r   <= err;
            last_drive_r <= '0;
            last_tick_r  <= now_r;
            first_r      <= 1'b0;
            pend_drive_r <= '0;
            pend_upd_r   <= 1'b0;
            state_r      <= ST_OUT;
          end else if (el == '0 || el < 32'(MIN_PERIOD_TICKS)) begin
            pend_drive_r <= last_drive_r;
            pend_upd_r   <= 1'b0;
            state_r      <= ST_OUT;
          end else begin
            op_r    <= OP_IE_MUL;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          neg_r   <= op_neg;
          state_r <= ST_BUSY;
        end
        ST_BUSY: begin
          if (eng_stat.done) begin
            unique case (op_r)
              OP_IE_MUL: begin
                tmp_r   <= eng_quo;
                op_r    <= OP_IE_DIV;
                state_r <= ST_LOAD;
              end
              OP_IE_DIV: begin
                isum_new_r <= isum_sat;
                op_r       <= OP_RATE;
                state_r    <= ST_LOAD;
              end
              OP_RATE: begin
                rate_r  <= qsgn;
                op_r    <= OP_F_MUL;
                state_r <= ST_LOAD;
              end
              OP_F_MUL: begin
                res_r   <= 50'(term);
                op_r    <= OP_P_MUL;
                state_r <= ST_LOAD;
              end
              OP_P_MUL: begin
                res_r   <= res_r + 50'(term);
                op_r    <= OP_D_MUL;
                state_r <= ST_LOAD;
              end
              OP_D_MUL: begin
                res_r   <= res_r + 50'(term);
                op_r    <= OP_I_MUL;
                state_r <= ST_LOAD;
              end
              OP_I_MUL: begin
                res_r     <= res_r + iterm;
                restore_r <= iclamp;
                state_r   <= ST_LIMIT;
              end
              OP_FL_MUL: begin
                fa_r    <= fb;
                op_r    <= OP_FR_MUL;
                state_r <= ST_LOAD;
              end
              OP_FR_MUL: begin
                final_r <= filt;
                state_r <= ST_COMMIT;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LIMIT: begin
          final_r   <= lres32;
          restore_r <= restore_r | lhit;
          if (filter_r != '0) begin
            op_r    <= OP_FL_MUL;
            state_r <= ST_LOAD;
          end else begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          last_drive_r <= final_r;
          last_tick_r  <= now_r;
          prev_err_r   <= err;
          if (!restore_r) begin
            isum_r <= isum_new_r;
          end
          pend_drive_r <= final_r;
          pend_upd_r   <= 1'b1;
          state_r      <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_drive_r   <= pend_drive_r;
      out_updated_r <= pend_upd_r;
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_updated = out_updated_r;

`ifndef NO_ASSERTIONS
  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.done |-> state_r == ST_BUSY)
    else $error("engine finished outside the busy state");
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_DECIDE)
    else $error("accepted word not followed by decision");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !eng_stat.busy)
    else $error("engine running while idle");
`endif

endmodule

// ----- src/pidf_shift_engine.sv -----
// Bit-serial unsigned multiply and restoring divide unit, one bit per cycle.
// Depends on pidf_pkg.
module pidf_shift_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  pidf_pkg::eng_cmd_t  cmd,
  input  logic [31:0]         opa,
  input  logic [63:0]         opb,
  output pidf_pkg::eng_stat_t stat,
  output logic [32:0]         acc,
  output logic [63:0]         quo
);
  import pidf_pkg::*;

  logic [32:0]      acc_r, acc_nxt;
  logic [63:0]      q_r, q_nxt;
  logic [31:0]      m_r;
  logic             div_r;
  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [32:0]      add_sum;
  logic [32:0]      shl;
  logic [33:0]      sub_d;

  always_comb begin
    add_sum = acc_r + (q_r[0] ? {1'b0, m_r} : 33'd0);
    shl     = {acc_r[31:0], q_r[63]};
    sub_d   = {1'b0, shl} - {2'b00, m_r};
    if (div_r) begin
      if (!sub_d[33]) begin
        acc_nxt = sub_d[32:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        acc_nxt = shl;
        q_nxt   = {q_r[62:0], 1'b0};
      end
    end else begin
      acc_nxt = {1'b0, add_sum[32:1]};
      q_nxt   = {add_sum[0], q_r[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      q_r   <= opb;
      m_r   <= opa;
      div_r <= cmd.is_div;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign acc       = acc_r;
  assign quo       = q_r;

endmodule

// ----- dv/pidf_controller_with_limits_tb.sv -----
// Self-checking testbench for the PIDF controller with limits.
// Depends on pidf_pkg and the pidf_controller_with_limits RTL; drives random and
// directed words, predicts every result in place and compares it field by field.
`timescale 1ns / 100ps

module pidf_controller_with_limits_tb;
  import pidf_pkg::*;

  localparam longint WLIM = 64'sh7FFF_FFFF_FFFF;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_measured = '0;
  logic signed [31:0] in_target = '0;
  logic [31:0] in_now_tick = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_drive;
  logic out_updated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pidf_controller_with_limits u_top (.*);

  always #2 clk = ~clk;

  typedef struct {
    logic signed [31:0] drive;
    logic updated;
  } drive_word_t;

  drive_word_t pending_drives[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_mode = 0;

  longint kp, ki, kd, kf, int_lim, lim_lo, lim_hi, filt;
  longint acc_sum, prev_err, last_out;
  logic [31:0] last_tick;
  bit seeding;
  logic [31:0] tick_now;

  function automatic longint sat_wide(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > S32MAX) return S32MAX;
    if (v < S32MIN) return S32MIN;
    return v;
  endfunction

  function automatic longint clamp_top_first(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint q16_product(longint a, longint b);
    bit neg;
    logic [63:0] ua, ub, hi, lo, p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    hi = ub >> 32;
    lo = ub & 64'hFFFF_FFFF;
    p = ((ua * hi) << 16) + ((ua * lo) >> 16);
    if (p > WLIM) p = WLIM;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  task automatic controller_reset_state();
    kp = 0; ki = 0; kd = 0; kf = 0; int_lim = 0; lim_lo = 0; lim_hi = 0; filt = 0;
    acc_sum = 0; prev_err = 0; last_out = 0; last_tick = 0; seeding = 1;
  endtask

  function automatic drive_word_t predict_drive(longint meas, longint tgt, logic [31:0] now);
    drive_word_t r;
    longint err, old_sum, f_t, p_t, d_t, i_t, rate, inc, res;
    logic [31:0] el;
    err = sat_s32(tgt - meas);
    old_sum = acc_sum;
    if (seeding) begin
      prev_err = err; last_out = 0; last_tick = now; seeding = 0;
      r.drive = 0; r.updated = 0;
      return r;
    end
    el = now - last_tick;
    if (el == 0 || el < MIN_PERIOD_TICKS) begin
      r.drive = last_out[31:0]; r.updated = 0;
      return r;
    end
    f_t = q16_product(kf, tgt);
    p_t = q16_product(kp, err);
    rate = ((err - prev_err) * 1000) / longint'(el);
    d_t = q16_product(kd, sat_wide(rate, WLIM));
    inc = sat_wide((err * longint'(el)) / 1000, WLIM);
    acc_sum = sat_wide(acc_sum + inc, WLIM);
    i_t = q16_product(ki, acc_sum);
    if (int_lim != 0 && !(-int_lim < i_t && i_t < int_lim)) begin
      i_t = clamp_top_first(i_t, -int_lim, int_lim);
      acc_sum = old_sum;
    end
    res = f_t + p_t + i_t + d_t;
    if (lim_lo != lim_hi && !(lim_lo < res && res < lim_hi)) begin
      res = clamp_top_first(res, lim_lo, lim_hi);
      acc_sum = old_sum;
    end
    res = sat_s32(res);
    if (filt != 0) res = (last_out * filt + res * (65536 - filt)) / 65536;
    last_out = res; last_tick = now; prev_err = err;
    r.drive = res[31:0]; r.updated = 1;
    return r;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_P: kp = longint'($signed(data));
      REG_GAIN_I: ki = longint'($signed(data));
      REG_GAIN_D: kd = longint'($signed(data));
      REG_GAIN_F: kf = longint'($signed(data));
      REG_INT_LIMIT: int_lim = data[30:0];
      REG_OUTPUT_LOW: lim_lo = longint'($signed(data));
      REG_OUTPUT_HIGH: lim_hi = longint'($signed(data));
      REG_FILTER: filt = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic send_sample(logic [31:0] meas, logic [31:0] tgt, logic [31:0] now);
    in_valid = 1'b1; in_measured = meas; in_target = tgt; in_now_tick = now;
    do @(posedge clk); while (!in_ready);
    pending_drives.push_back(predict_drive(longint'($signed(meas)),
                                           longint'($signed(tgt)), now));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random_burst(int n, int step_max, bit wide);
    logic [31:0] m, t;
    repeat (n) begin
      if (wide) begin
        m = $urandom; t = $urandom;
      end else begin
        m = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        t = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      end
      tick_now += $urandom_range(0, step_max);
      send_sample(m, t, tick_now);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic test_seed_and_hold();
    tick_now = 32'h1000;
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, tick_now);
    send_sample(0, 32'h0001_0000, tick_now);
    send_sample(0, 32'h0001_0000, tick_now + 19);
    wait_drained();
    write_reg(REG_GAIN_P, 32'h0001_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, tick_now + 20);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, tick_now + 40);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFF0);
    send_sample(0, 0, 32'h0000_0010);
    tick_now = 32'h10;
    wait_drained();
  endtask

  task automatic test_gain_extremes();
    write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_I, 32'h8000_0000);
    write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_F, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, tick_now + 20);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, tick_now + 41);
    send_sample(0, 0, tick_now + 32'hFFFF_0000);
    tick_now += 32'hFFFF_0000;
    send_random_burst(6, 32'hFFFF_FFFF, 1);
    wait_drained();
  endtask

  task automatic test_limits_and_filter();
    write_reg(REG_INT_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_OUTPUT_LOW, 32'hFFFF_0000);
    write_reg(REG_OUTPUT_HIGH, 32'h0001_0000);
    write_reg(REG_FILTER, 32'h0000_FFFF);
    send_random_burst(4, 1000, 1);
    wait_drained();
    write_reg(REG_INT_LIMIT, 32'h0000_0001);
    write_reg(REG_FILTER, 32'h0000_0001);
    write_reg(REG_OUTPUT_LOW, 32'h7FFF_FFFF);
    write_reg(REG_OUTPUT_HIGH, 32'h8000_0000);
    send_random_burst(4, 1000, 1);
    wait_drained();
    write_reg(4'd9, 32'hDEAD_BEEF);
  endtask

  task automatic test_random_settings();
    repeat (42) begin
      write_reg(REG_GAIN_P, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4_0000) - 32'h2_0000);
      write_reg(REG_GAIN_I, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4_0000) - 32'h2_0000);
      write_reg(REG_GAIN_D, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h400) - 32'h200);
      write_reg(REG_GAIN_F, $urandom_range(0, 32'h4_0000) - 32'h2_0000);
      write_reg(REG_INT_LIMIT, $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 32'h0010_0000));
      write_reg(REG_OUTPUT_LOW, $urandom_range(0, 1) ? -$urandom_range(0, 32'h0020_0000) : 32'd0);
      write_reg(REG_OUTPUT_HIGH, $urandom_range(0, 32'h0020_0000));
      write_reg(REG_FILTER, $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 65535));
      send_random_burst(40, 200, $urandom_range(0, 7) == 0);
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (stall_mode) out_ready <= ($urandom_range(0, 2) == 0);
    else out_ready <= 1'b1;
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
  end

  always @(posedge clk) begin
    drive_word_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected word: drive %0d updated %0b", out_drive, out_updated);
        errors++;
      end else begin
        exp_word = pending_drives.pop_front();
        if (out_drive !== exp_word.drive) begin
          $error("drive: expected %0d, got %0d", exp_word.drive, out_drive);
          errors++;
        end
        if (out_updated !== exp_word.updated) begin
          $error("updated: expected %0b, got %0b", exp_word.updated, out_updated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("pidf_controller_with_limits regression: fail");
      $finish;
    end
  end

  initial begin
    controller_reset_state();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_seed_and_hold();
    test_gain_extremes();
    test_limits_and_filter();
    test_random_settings();
    wait_drained();
    if (errors == 0 && pending_drives.size() == 0) begin
      $display("pidf_controller_with_limits regression: pass");
    end else begin
      $display("pidf_controller_with_limits regression: fail");
    end
    $finish;
  end

endmodule
